>>> hdl/sorted_max_priority_queue_macros.svh
// Assertion macros for the sorted max priority queue.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define SMPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("smpq assertion failed");
// Check a property on every rising clock edge, reset included
`define SMPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("smpq assertion failed");
`else
`define SMPQ_ASSERT(lbl, prop)
`define SMPQ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> hdl/smpq_pkg.sv
// Shared types and constants for the sorted max priority queue.
// No dependencies; used by smpq_cell and sorted_max_priority_queue.
package smpq_pkg;

  localparam int DEPTH       = 128;
  localparam int VAL_W       = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_OUT_W = 8;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic             en;
    logic             pop;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hdl/smpq_cell.sv
// One storage cell of the sorted chain: holds a value, compares it with the
// broadcast insert value and shifts to or from its neighbors. Uses smpq_pkg.
module smpq_cell
  import smpq_pkg::*;
(
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             occ_i,        // this cell holds a live entry
  input  logic             prev_stay_i,  // upper neighbor keeps its value
  input  logic [VAL_W-1:0] prev_value_i, // upper neighbor's value
  input  logic [VAL_W-1:0] next_value_i, // lower neighbor's value
  output logic             stay_o,
  output logic [VAL_W-1:0] value_o
);

  logic [VAL_W-1:0] value_q, value_d;

  // Keep the entry when the new value is strictly smaller
  assign stay_o = occ_i && (ctrl_i.value < value_q);

  // Pop shifts up; insert keeps, takes the new value, or shifts down
  always_comb begin
    value_d = value_q;
    if (ctrl_i.en) begin
      if (ctrl_i.pop) begin
        value_d = next_value_i;
      end else if (stay_o) begin
        value_d = value_q;
      end else if (prev_stay_i) begin
        value_d = ctrl_i.value;
      end else begin
        value_d = prev_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> hdl/sorted_max_priority_queue.sv
// Top level of the sorted max priority queue: a chain of smpq_cell cells,
// the entry counter and the result register. Uses smpq_pkg and the macros header.
//
// Usage:
//   Slave side: s_axis_tuser carries the operation (insert or pop),
//   s_axis_tdata the 16-bit value to insert. Master side: one result per
//   transaction, with the popped value and entry count in m_axis_tdata and
//   the status in m_axis_tuser.
//   Every cell compares the broadcast value with its own entry in the same
//   cycle, so an insert or pop completes whatever the fill level. The result
//   of an accepted transaction is registered for the next cycle; throughput
//   is one item per cycle while the receiver keeps taking results.
//   A single output register parts the two sides: s_axis_tready stays high
//   while that register is empty or is being emptied in the same cycle. When
//   the receiver stalls, the result holds and no further item is taken.
//   A pop on an empty queue reports status empty; an insert into a full
//   queue is dropped and reports status full.
//   Reset clears the entry count and the result valid flag and status; the
//   cell contents need no clearing, as only entries below the count are ever read.
`include "sorted_max_priority_queue_macros.svh"
module sorted_max_priority_queue
  import smpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] value
  input  logic        s_axis_tuser,  // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] popped_value, [23:16] entry_count
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  logic             in_acc;
  kind_e            kind;
  logic             is_pop, is_empty, is_full;
  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEPTH-1:0] occ, stay;
  logic [VAL_W-1:0] cell_val [DEPTH];

  logic                   out_valid_q;
  logic [VAL_W-1:0]       out_value_q, out_value_d;
  status_e                out_status_q, out_status_d;
  logic [COUNT_OUT_W-1:0] out_count_q;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  // Decode the incoming transaction
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind          = kind_e'(s_axis_tuser);
  assign is_pop        = (kind == KIND_POP);
  assign is_empty      = (cnt_q == '0);
  assign is_full       = (cnt_q == CNT_W'(DEPTH));

  assign ctrl.en    = in_acc && !(is_pop && is_empty) && !(!is_pop && is_full);
  assign ctrl.pop   = is_pop;
  assign ctrl.value = s_axis_tdata;

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (cnt_q > CNT_W'(i));
    if (i == 0) begin : g_head
      smpq_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occ_i        (occ[i]),
        .prev_stay_i  (1'b1),
        .prev_value_i (s_axis_tdata),
        .next_value_i (cell_val[i+1]),
        .stay_o       (stay[i]),
        .value_o      (cell_val[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      smpq_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occ_i        (occ[i]),
        .prev_stay_i  (stay[i-1]),
        .prev_value_i (cell_val[i-1]),
        .next_value_i (cell_val[i]),
        .stay_o       (stay[i]),
        .value_o      (cell_val[i])
      );
    end else begin : g_mid
      smpq_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occ_i        (occ[i]),
        .prev_stay_i  (stay[i-1]),
        .prev_value_i (cell_val[i-1]),
        .next_value_i (cell_val[i+1]),
        .stay_o       (stay[i]),
        .value_o      (cell_val[i])
      );
    end
  end

  // Advance the entry count and form the result
  always_comb begin
    cnt_d        = cnt_q;
    out_value_d  = '0;
    out_status_d = ST_OK;
    if (is_pop) begin
      if (is_empty) begin
        out_status_d = ST_EMPTY;
      end else begin
        out_value_d = cell_val[0];
        cnt_d       = cnt_q - CNT_W'(1);
      end
    end else begin
      if (is_full) begin
        out_status_d = ST_FULL;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_d};

  // Hold count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
    end else begin
      if (in_acc) begin
        cnt_q        <= cnt_d;
        out_valid_q  <= 1'b1;
        out_status_q <= out_status_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q <= out_value_d;
      out_count_q <= cnt_ext[COUNT_OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_count_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

  // Checks on the count, the pop-on-empty status and the ordering of the chain head
  `SMPQ_ASSERT_ALWAYS(a_count_bound, !rst_ni || cnt_q <= CNT_W'(DEPTH))
  `SMPQ_ASSERT(a_pop_empty, in_acc && is_pop && is_empty |=> out_status_q == ST_EMPTY)
  `SMPQ_ASSERT(a_insert_count, in_acc && !is_pop && !is_full |=> cnt_q == $past(cnt_q) + CNT_W'(1))
  `SMPQ_ASSERT(a_head_sorted, occ[1] |-> cell_val[0] >= cell_val[1])

endmodule
